/* sv/olist_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered list engine package
// Shared sizes, operation and status codes, payload types, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package olist_pkg;

   // Storage geometry.
   localparam int CAPACITY    = 64;
   localparam int ENTRY_WIDTH = 32;

   // Fixed field widths of the beats.
   localparam int MODE_W   = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;

   // Derived widths.
   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int CNT1_W  = COUNT_W + 1;
   localparam int CMP_W   = ((COUNT_W > POS_W) ? COUNT_W : POS_W) + 1;

   // Operation codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TAIL   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FIND   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd6;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic [LEN_W-1:0]    found_position;
      logic [LEN_W-1:0]    length;
      logic                is_empty;
   } rsp_type;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_READ,
      DP_READ_TAIL,
      DP_CAPTURE,
      DP_CAPTURE_NEXT,
      DP_INS_BEGIN,
      DP_INS_WRITE,
      DP_SHIFT_UP,
      DP_SHIFT_DOWN,
      DP_FIND_BEGIN,
      DP_FIND_STEP,
      DP_CLEAR,
      DP_RESPOND
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      logic                pop;
      logic                set_status;
      logic [STATUS_W-1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              empty;
      logic              full;
      logic              ins_at_end;
      logic              up_last;
      logic              down_last;
      logic              idx_last;
      logic              hit;
   } dp_stat_type;

endpackage

/* sv/ordered_list_engine.sv */
// ----------------------------------------------------------------------------
// Ordered list engine
// Fixed-capacity ordered list of words with positional read, insert, append,
// delete, tail delete, find and clear, one operation per request beat.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and answers with exactly one response
// beat. The entries live in a RAM with one write and one registered read
// port, and insert, delete and find walk it one entry per cycle, so the time
// per beat follows the walk: read, delete tail, append and clear take no walk;
// insert and delete walk between the position and the end of the list, and
// find walks from the head up to the match or to the end. A finished response
// waits in its own register, so the next request is taken while it is still
// unclaimed. No clearing pass runs after reset: the length alone marks the
// valid entries.
// ----------------------------------------------------------------------------
module ordered_list_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  olist_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output olist_pkg::rsp_type rsp_data
);
   import olist_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer.
   olist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store, length and result registers.
   olist_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

/* sv/olist_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* sv/olist_datapath.sv */
// ----------------------------------------------------------------------------
// Ordered list datapath
// Holds the entry store, the length, the walking index and the result, and
// carries out one controller operation per cycle.
// ----------------------------------------------------------------------------
module olist_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  olist_pkg::req_type    req_data,
   input  olist_pkg::dp_cmd_type cmd,
   output olist_pkg::dp_stat_type stat,
   output olist_pkg::rsp_type    rsp_data
);
   import olist_pkg::*;

   logic [MODE_W-1:0]      mode_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [ENTRY_WIDTH-1:0] val_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     idx_ff;
   logic [COUNT_W-1:0]     lim_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic [ENTRY_WIDTH-1:0] rdval_ff;
   logic [COUNT_W-1:0]     found_ff;
   rsp_type                rsp_ff;

   logic [CMP_W-1:0]       pos_ext;
   logic [CMP_W-1:0]       cnt_ext;
   logic [COUNT_W-1:0]     pos_m1;
   logic [COUNT_W-1:0]     rd_p0;
   logic [COUNT_W-1:0]     ins_p0;
   logic [COUNT_W-1:0]     ins_target;

   logic                   rd_en;
   logic [COUNT_W-1:0]     rd_idx;
   logic                   wr_en;
   logic [COUNT_W-1:0]     wr_idx;
   logic [ENTRY_WIDTH-1:0] wr_data;
   logic [ENTRY_WIDTH-1:0] rd_data;

   // Clamp the one-based position to a zero-based index for each operation.
   always_comb begin
      pos_ext = CMP_W'(pos_ff);
      cnt_ext = CMP_W'(count_ff);
      pos_m1  = COUNT_W'(pos_ext - CMP_W'(1));
      if (pos_ff == '0) begin
         rd_p0 = '0;
      end else if (pos_ext > cnt_ext) begin
         rd_p0 = count_ff - COUNT_W'(1);
      end else begin
         rd_p0 = pos_m1;
      end
      if (pos_ff == '0) begin
         ins_p0 = '0;
      end else if (pos_ext > cnt_ext + CMP_W'(1)) begin
         ins_p0 = count_ff;
      end else begin
         ins_p0 = pos_m1;
      end
      ins_target = (mode_ff == MODE_APPEND) ? count_ff : ins_p0;
   end

   // Status toward the controller.
   always_comb begin
      stat.mode       = mode_ff;
      stat.empty      = (count_ff == '0);
      stat.full       = (count_ff == COUNT_W'(CAPACITY));
      stat.ins_at_end = (ins_target == count_ff);
      stat.up_last    = ((idx_ff - COUNT_W'(1)) == lim_ff);
      stat.down_last  = ((CNT1_W'(idx_ff) + CNT1_W'(2)) >= CNT1_W'(count_ff));
      stat.idx_last   = ((idx_ff + COUNT_W'(1)) == count_ff);
      stat.hit        = (rd_data == val_ff);
   end

   // Store port addressing for each operation.
   always_comb begin
      rd_en   = 1'b0;
      rd_idx  = '0;
      wr_en   = 1'b0;
      wr_idx  = idx_ff;
      wr_data = rd_data;
      unique case (cmd.op) inside
         DP_READ: begin
            rd_en  = 1'b1;
            rd_idx = rd_p0;
         end
         DP_READ_TAIL, DP_INS_BEGIN: begin
            rd_en  = 1'b1;
            rd_idx = count_ff - COUNT_W'(1);
         end
         DP_INS_WRITE: begin
            wr_en   = 1'b1;
            wr_idx  = lim_ff;
            wr_data = val_ff;
         end
         DP_SHIFT_UP: begin
            wr_en  = 1'b1;
            rd_en  = 1'b1;
            rd_idx = idx_ff - COUNT_W'(2);
         end
         DP_SHIFT_DOWN: begin
            wr_en  = 1'b1;
            rd_en  = 1'b1;
            rd_idx = idx_ff + COUNT_W'(2);
         end
         DP_CAPTURE_NEXT: begin
            rd_en  = 1'b1;
            rd_idx = idx_ff + COUNT_W'(1);
         end
         DP_FIND_BEGIN: begin
            rd_en  = 1'b1;
            rd_idx = '0;
         end
         DP_FIND_STEP: begin
            rd_en  = !stat.hit;
            rd_idx = idx_ff + COUNT_W'(1);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   olist_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // List length.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.op == DP_INS_WRITE) begin
         count_ff <= count_ff + COUNT_W'(1);
      end else if (cmd.op == DP_CLEAR) begin
         count_ff <= '0;
      end else if (cmd.pop) begin
         count_ff <= count_ff - COUNT_W'(1);
      end
   end

   // Item, index and result registers.
   always_ff @(posedge clock) begin
      case (cmd.op) inside
         DP_LOAD: begin
            mode_ff   <= req_data.mode;
            pos_ff    <= req_data.position;
            val_ff    <= ENTRY_WIDTH'(req_data.value);
            status_ff <= STATUS_OK;
            rdval_ff  <= '0;
            found_ff  <= '0;
         end
         DP_READ: begin
            idx_ff <= rd_p0;
         end
         DP_INS_BEGIN: begin
            idx_ff <= count_ff;
            lim_ff <= ins_target;
         end
         DP_CAPTURE, DP_CAPTURE_NEXT: begin
            rdval_ff <= rd_data;
         end
         DP_SHIFT_UP: begin
            idx_ff <= idx_ff - COUNT_W'(1);
         end
         DP_SHIFT_DOWN: begin
            idx_ff <= idx_ff + COUNT_W'(1);
         end
         DP_FIND_BEGIN: begin
            idx_ff <= '0;
         end
         DP_FIND_STEP: begin
            if (stat.hit) begin
               found_ff <= idx_ff + COUNT_W'(1);
            end else begin
               idx_ff <= idx_ff + COUNT_W'(1);
            end
         end
         DP_RESPOND: begin
            rsp_ff.status         <= status_ff;
            rsp_ff.read_value     <= VALUE_W'(rdval_ff);
            rsp_ff.found_position <= LEN_W'(found_ff);
            rsp_ff.length         <= LEN_W'(count_ff);
            rsp_ff.is_empty       <= (count_ff == '0);
         end
         default: begin
         end
      endcase
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* sv/olist_ctrl.sv */
// ----------------------------------------------------------------------------
// Ordered list controller
// Sequences each operation through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module olist_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  olist_pkg::dp_stat_type stat,
   output olist_pkg::dp_cmd_type  cmd
);
   import olist_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_READ_WAIT,
      S_INS_WRITE,
      S_SHIFT_UP,
      S_DEL_CAPTURE,
      S_SHIFT_DOWN,
      S_FIND,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and datapath command.
   always_comb begin
      state_in       = state_ff;
      cmd.op         = DP_NONE;
      cmd.pop        = 1'b0;
      cmd.set_status = 1'b0;
      cmd.status     = STATUS_OK;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            unique case (stat.mode) inside
               MODE_READ, MODE_DELETE, MODE_TAIL: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STATUS_EMPTY;
                  end else if (stat.mode == MODE_READ) begin
                     cmd.op   = DP_READ;
                     state_in = S_READ_WAIT;
                  end else if (stat.mode == MODE_DELETE) begin
                     cmd.op   = DP_READ;
                     state_in = S_DEL_CAPTURE;
                  end else begin
                     cmd.op   = DP_READ_TAIL;
                     state_in = S_READ_WAIT;
                  end
               end
               MODE_INSERT, MODE_APPEND: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STATUS_FULL;
                  end else begin
                     cmd.op   = DP_INS_BEGIN;
                     state_in = stat.ins_at_end ? S_INS_WRITE : S_SHIFT_UP;
                  end
               end
               MODE_FIND: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STATUS_NOT_FOUND;
                  end else begin
                     cmd.op   = DP_FIND_BEGIN;
                     state_in = S_FIND;
                  end
               end
               MODE_CLEAR: begin
                  cmd.op = DP_CLEAR;
               end
               default: begin
                  cmd.op = DP_NONE;
               end
            endcase
         end
         S_READ_WAIT: begin
            cmd.op   = DP_CAPTURE;
            cmd.pop  = (stat.mode == MODE_TAIL);
            state_in = S_FINISH;
         end
         S_SHIFT_UP: begin
            cmd.op = DP_SHIFT_UP;
            if (stat.up_last) begin
               state_in = S_INS_WRITE;
            end
         end
         S_INS_WRITE: begin
            cmd.op   = DP_INS_WRITE;
            state_in = S_FINISH;
         end
         S_DEL_CAPTURE: begin
            cmd.op = DP_CAPTURE_NEXT;
            if (stat.idx_last) begin
               cmd.pop  = 1'b1;
               state_in = S_FINISH;
            end else begin
               state_in = S_SHIFT_DOWN;
            end
         end
         S_SHIFT_DOWN: begin
            cmd.op = DP_SHIFT_DOWN;
            if (stat.down_last) begin
               cmd.pop  = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_FIND: begin
            cmd.op = DP_FIND_STEP;
            if (stat.hit) begin
               state_in = S_FINISH;
            end else if (stat.idx_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = STATUS_NOT_FOUND;
               state_in       = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.op       = DP_RESPOND;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* tb/sv/ordered_list_engine_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives request beats of every operation through the valid/ready handshake,
// keeps its own copy of the list to work out each response, and compares
// every response beat field by field under random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module ordered_list_engine_test;
   import olist_pkg::*;

   // Mode code that the engine does not decode.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

   // Cycles without any accepted beat before the run is abandoned.
   localparam int QUIET_LIMIT = 2000;
   // Settling time after the last response, above the longest operation.
   localparam int SETTLE_CYCLES = 100;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the list, updated when a request beat is accepted.
   logic [ENTRY_WIDTH-1:0] list_words [CAPACITY];
   int                     list_len;
   rsp_type                expected_rsps [$];

   // Knobs for the idling of both sides.
   bit req_gaps_on   = 1'b1;
   bit rsp_stalls_on = 1'b1;

   int          mismatches;
   int          req_count;
   int          rsp_count;
   int          status_seen [4];
   int unsigned quiet_cycles;

   ordered_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Limit a 1-based position to the range 1..top.
   function automatic int clamp_position(int pos, int top);
      if (pos < 1) return 1;
      if (pos > top) return top;
      return pos;
   endfunction

   // Apply one operation to the shadow list and return the response it earns.
   function automatic rsp_type apply_list_op(req_type beat);
      rsp_type                res;
      int                     p;
      int                     k;
      logic [ENTRY_WIDTH-1:0] word;
      word = beat.value[ENTRY_WIDTH-1:0];
      res  = '0;
      case (beat.mode)
         MODE_READ: begin
            if (list_len == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               p = clamp_position(beat.position, list_len);
               res.read_value = list_words[p-1];
            end
         end
         MODE_INSERT: begin
            if (list_len >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               p = clamp_position(beat.position, list_len + 1);
               for (k = list_len; k >= p; k--) list_words[k] = list_words[k-1];
               list_words[p-1] = word;
               list_len++;
            end
         end
         MODE_APPEND: begin
            if (list_len >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               list_words[list_len] = word;
               list_len++;
            end
         end
         MODE_DELETE: begin
            if (list_len == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               p = clamp_position(beat.position, list_len);
               res.read_value = list_words[p-1];
               for (k = p - 1; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
               list_len--;
            end
         end
         MODE_TAIL: begin
            if (list_len == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.read_value = list_words[list_len-1];
               list_len--;
            end
         end
         MODE_FIND: begin
            res.status = STATUS_NOT_FOUND;
            for (k = 0; k < list_len; k++) begin
               if (list_words[k] == word) begin
                  res.status         = STATUS_OK;
                  res.found_position = LEN_W'(k + 1);
                  break;
               end
            end
         end
         MODE_CLEAR: begin
            list_len = 0;
         end
         default: begin
         end
      endcase
      res.length   = LEN_W'(list_len);
      res.is_empty = (list_len == 0);
      return res;
   endfunction

   // Idle length for either side: mostly short, now and then long.
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one request beat and record the response it should produce.
   task automatic send_beat(input req_type beat);
      int gap;
      gap = req_gaps_on ? pick_idle() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(apply_list_op(beat));
      req_count++;
   endtask

   task automatic send_op(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                          input logic [VALUE_W-1:0] value);
      req_type beat;
      beat.mode     = mode;
      beat.position = pos;
      beat.value    = value;
      send_beat(beat);
   endtask

   // Hold the sender off until every outstanding response has come back.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Compare one response beat against the oldest expected response.
   task automatic check_rsp(input rsp_type got);
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         mismatches++;
         $display("%0t: response beat with nothing outstanding, expected none, actual %h",
                  $time, got);
         return;
      end
      want = expected_rsps.pop_front();
      rsp_count++;
      status_seen[got.status]++;
      if (got.status !== want.status) begin
         mismatches++;
         $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
      end
      if (got.read_value !== want.read_value) begin
         mismatches++;
         $display("%0t: read_value expected %h, actual %h", $time, want.read_value,
                  got.read_value);
      end
      if (got.found_position !== want.found_position) begin
         mismatches++;
         $display("%0t: found_position expected %0d, actual %0d", $time,
                  want.found_position, got.found_position);
      end
      if (got.length !== want.length) begin
         mismatches++;
         $display("%0t: length expected %0d, actual %0d", $time, want.length, got.length);
      end
      if (got.is_empty !== want.is_empty) begin
         mismatches++;
         $display("%0t: is_empty expected %0d, actual %0d", $time, want.is_empty,
                  got.is_empty);
      end
   endtask

   // Response checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_rsp(rsp_data);
   end

   // Receiver: ready runs broken by stalls of random length.
   initial begin : rsp_side
      int hold;
      wait (!reset);
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if (rsp_stalls_on) begin
            hold = pick_idle();
            if (hold > 0) begin
               rsp_ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
         end
      end
   end

   // Watchdog: count cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: watchdog expired, %0d cycles without a beat", $time, QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // Value for a random beat: full range, a small pool for duplicates, or a
   // word already in the list so that find hits.
   function automatic logic [VALUE_W-1:0] pick_value(bit for_find);
      int r;
      r = $urandom_range(0, 99);
      if (for_find && list_len > 0 && r < 60) return list_words[$urandom_range(0, list_len - 1)];
      if (r < 35) return $urandom_range(0, 7);
      if (r < 42) return '1;
      return $urandom;
   endfunction

   // Position for a random beat: mostly inside the list, some below and beyond.
   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return POS_W'($urandom_range(1, list_len + 1));
      if (r < 85) return '0;
      return POS_W'($urandom_range(0, 127));
   endfunction

   // Edge cases of every operation on a short list.
   task automatic test_directed();
      send_op(MODE_READ,   7'd1,   32'h0000_0000);
      send_op(MODE_DELETE, 7'd1,   32'h0000_0000);
      send_op(MODE_TAIL,   7'd0,   32'h0000_0000);
      send_op(MODE_FIND,   7'd0,   32'h0000_0000);
      send_op(MODE_UNUSED, 7'h7F,  32'hFFFF_FFFF);
      send_op(MODE_APPEND, 7'd0,   32'h0000_0000);
      send_op(MODE_APPEND, 7'h7F,  32'hFFFF_FFFF);
      send_op(MODE_INSERT, 7'd0,   32'h1111_1111);
      send_op(MODE_INSERT, 7'h7F,  32'h2222_2222);
      send_op(MODE_INSERT, 7'd2,   32'hA5A5_A5A5);
      // Position exactly one past the end.
      send_op(MODE_INSERT, 7'd6,   32'h5A5A_5A5A);
      send_op(MODE_READ,   7'd0,   32'h0000_0000);
      send_op(MODE_READ,   7'h7F,  32'h0000_0000);
      send_op(MODE_READ,   7'd3,   32'hFFFF_FFFF);
      send_op(MODE_FIND,   7'd0,   32'hFFFF_FFFF);
      send_op(MODE_FIND,   7'h7F,  32'h1234_5678);
      send_op(MODE_UNUSED, 7'd3,   32'h0000_0000);
      send_op(MODE_DELETE, 7'd0,   32'h0000_0000);
      send_op(MODE_DELETE, 7'h7F,  32'h0000_0000);
      send_op(MODE_DELETE, 7'd2,   32'h0000_0000);
      send_op(MODE_TAIL,   7'd0,   32'h0000_0000);
      send_op(MODE_CLEAR,  7'h55,  32'hDEAD_BEEF);
      send_op(MODE_READ,   7'd1,   32'h0000_0000);
      // Old words stay in the store after a clear and must not be found.
      send_op(MODE_FIND,   7'd0,   32'h1111_1111);
      wait_results_drained();
   endtask

   task automatic fill_to_capacity();
      while (list_len < CAPACITY) begin
         if ($urandom_range(0, 1)) send_op(MODE_INSERT, pick_position(), pick_value(1'b0));
         else send_op(MODE_APPEND, 7'd0, pick_value(1'b0));
      end
   endtask

   // Full list: the refusals, walks over the whole store, and clear at full.
   task automatic test_full_list();
      int i;
      send_op(MODE_CLEAR, 7'd0, 32'h0000_0000);
      fill_to_capacity();
      send_op(MODE_APPEND, 7'd0,  32'hFFFF_FFFF);
      send_op(MODE_INSERT, 7'd0,  32'h0000_0000);
      send_op(MODE_INSERT, 7'h7F, 32'h1357_9BDF);
      send_op(MODE_FIND,   7'd0,  list_words[CAPACITY-1]);
      send_op(MODE_FIND,   7'd0,  32'hC0DE_0BAD);
      send_op(MODE_READ,   7'd64, 32'h0000_0000);
      send_op(MODE_READ,   7'h7F, 32'h0000_0000);
      send_op(MODE_DELETE, 7'd1,  32'h0000_0000);
      for (i = 0; i < CAPACITY / 2; i++) begin
         if ($urandom_range(0, 3) == 0) send_op(MODE_TAIL, pick_position(), 32'h0);
         else send_op(MODE_DELETE, pick_position(), 32'h0);
      end
      wait_results_drained();
      fill_to_capacity();
      send_op(MODE_TAIL,  7'd0, 32'h0000_0000);
      send_op(MODE_APPEND, 7'd0, 32'h8000_0001);
      send_op(MODE_CLEAR, 7'd0, 32'h0000_0000);
      send_op(MODE_TAIL,  7'd0, 32'h0000_0000);
      wait_results_drained();
   endtask

   // Random mix that swings the length between empty and full.
   task automatic test_random_mix(input int count);
      int                i;
      int                r;
      bit                growing;
      logic [MODE_W-1:0] mode;
      growing = 1'b1;
      for (i = 0; i < count; i++) begin
         // A stretch with neither side idling.
         req_gaps_on   = !(i >= count / 3 && i < count / 2);
         rsp_stalls_on = req_gaps_on;
         if (list_len >= CAPACITY) growing = 1'b0;
         else if (list_len == 0) growing = 1'b1;
         else if ($urandom_range(0, 39) == 0) growing = !growing;
         r = $urandom_range(0, 99);
         if (r < 2)       mode = MODE_CLEAR;
         else if (r < 4)  mode = MODE_UNUSED;
         else if (r < 16) mode = MODE_READ;
         else if (r < 32) mode = MODE_FIND;
         else if (r < 66) mode = growing ? MODE_INSERT : MODE_DELETE;
         else if (r < 84) mode = growing ? MODE_APPEND : MODE_TAIL;
         else if (r < 94) mode = growing ? MODE_DELETE : MODE_INSERT;
         else             mode = growing ? MODE_TAIL : MODE_APPEND;
         send_op(mode, pick_position(), pick_value(mode == MODE_FIND));
         // Now and then the sender waits for every response.
         if ($urandom_range(0, 39) == 0) wait_results_drained();
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_list();
      test_random_mix(240);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d request beats and %0d checked responses.", req_count,
               rsp_count);
      $display("Status counts: ok %0d, empty %0d, full %0d, not found %0d.",
               status_seen[STATUS_OK], status_seen[STATUS_EMPTY],
               status_seen[STATUS_FULL], status_seen[STATUS_NOT_FOUND]);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
